[hw/rtl/fixed_block_slab_allocator_core_assert.svh]
// assertion macros used by the checker file
`ifndef FIXED_BLOCK_SLAB_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_SLAB_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FBSA_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbsa check failed");

// next-cycle implication, sampled on clk, off during reset
`define FBSA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbsa check failed");

`endif

[hw/rtl/fbsa_pkg.sv]
package fbsa_pkg;

    // default sizing
    localparam int MAX_SLABS_DEF       = 8;
    localparam int BLOCKS_PER_SLAB_DEF = 256;
    localparam int HEADER_BYTES_DEF    = 16;

    // fixed field widths
    localparam int BS_W       = 17;
    localparam int ADDR_W     = 32;
    localparam int FREE_OUT_W = 12;
    localparam int BS_MIN     = 8;

    typedef enum logic [1:0] {
        OP_GROW  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_OWNED = 3'd2,
        ST_FULL      = 3'd3,
        ST_SMALL     = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MUL_CAP   = 2'd0,
        MUL_TOTAL = 2'd1,
        MUL_IDX   = 2'd2
    } mul_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     scan_dec;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     div_step;
        logic     ram_rd;
        logic     commit_grow;
        logic     grow_cap;
        logic     commit_fresh;
        logic     commit_pop;
        logic     commit_free;
        logic     set_addr;
        logic     set_status;
        status_t  code;
        logic     out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic slab_full;
        logic grow_small;
        logic cap_hit;
        logic scan_zero;
        logic has_free;
        logic stacked;
        logic in_range;
        logic overflow;
        logic div_last;
        logic quo_zero;
        logic baddr_zero;
        logic out_free;
    } dp_stat_t;

endpackage

[hw/rtl/fixed_block_slab_allocator_core.sv]
// channel | signals                                   | direction
// in      | in_valid, in_ready, func, region_base,    | beat into the block
//         | region_length, block_address              |
// out     | out_valid, out_ready, granted_address,    | beat out of the block
//         | status, free_blocks                       |
// cfg     | cfg_write, cfg_data                       | block_size write, no wait
//
// one item at a time, taken only while the sequencer idles
// grow: table and header checks, capacity product, then a capped commit or a bit-serial divide
// alloc: scan slabs newest first, take a fresh block or pop the link stack, form the address
// free: a zero address returns ok without a scan; else find the owning slab, divide the offset
// ready again in the cycle after the result loads; a held result stalls the next item at its end
// rst_n empties the table, zeroes the free total, sets block_size to 8, idles the sequencer
module fixed_block_slab_allocator_core #(
    parameter int MAX_SLABS       = fbsa_pkg::MAX_SLABS_DEF,
    parameter int BLOCKS_PER_SLAB = fbsa_pkg::BLOCKS_PER_SLAB_DEF,
    parameter int HEADER_BYTES    = fbsa_pkg::HEADER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      func,
    input  logic [fbsa_pkg::ADDR_W-1:0]     region_base,
    input  logic [fbsa_pkg::ADDR_W-1:0]     region_length,
    input  logic [fbsa_pkg::ADDR_W-1:0]     block_address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fbsa_pkg::ADDR_W-1:0]     granted_address,
    output logic [2:0]                      status,
    output logic [fbsa_pkg::FREE_OUT_W-1:0] free_blocks,
    input  logic                            cfg_write,
    input  logic [fbsa_pkg::BS_W-1:0]       cfg_data
);

    import fbsa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    fbsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slab table, arithmetic and output register
    fbsa_datapath #(
        .MAX_SLABS       (MAX_SLABS),
        .BLOCKS_PER_SLAB (BLOCKS_PER_SLAB),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .func            (func),
        .region_base     (region_base),
        .region_length   (region_length),
        .block_address   (block_address),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_address (granted_address),
        .status          (status),
        .free_blocks     (free_blocks)
    );

endmodule

[hw/rtl/fbsa_ram.sv]
module fbsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/fbsa_ctrl.sv]
module fbsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fbsa_pkg::dp_stat_t stat,
    output fbsa_pkg::dp_cmd_t  cmd
);

    import fbsa_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DISPATCH = 12'b0000_0000_0010,
        S_GCAP     = 12'b0000_0000_0100,
        S_DIV      = 12'b0000_0000_1000,
        S_DIVEND   = 12'b0000_0001_0000,
        S_ASCAN    = 12'b0000_0010_0000,
        S_APOP     = 12'b0000_0100_0000,
        S_AMUL     = 12'b0000_1000_0000,
        S_AADDR    = 12'b0001_0000_0000,
        S_FSCAN    = 12'b0010_0000_0000,
        S_FCHK     = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencing of one operation
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_GROW:
                    begin
                        if (stat.slab_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.code       = ST_FULL;
                            state_next     = S_DONE;
                        end
                        else if (stat.grow_small)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.code       = ST_SMALL;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.mul_en  = 1'b1;
                            cmd.mul_sel = MUL_CAP;
                            state_next  = S_GCAP;
                        end
                    end
                    OP_ALLOC:
                    begin
                        state_next = S_ASCAN;
                    end
                    OP_FREE:
                    begin
                        if (stat.baddr_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.code       = ST_OK;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FSCAN;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = ST_OK;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_GCAP:
            begin
                if (stat.cap_hit)
                begin
                    cmd.commit_grow = 1'b1;
                    cmd.grow_cap    = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.code        = ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND:
            begin
                cmd.set_status = 1'b1;
                cmd.code       = ST_OK;
                if (stat.op == OP_GROW)
                begin
                    if (stat.quo_zero)
                    begin
                        cmd.code = ST_SMALL;
                    end
                    else
                    begin
                        cmd.commit_grow = 1'b1;
                    end
                end
                else
                begin
                    cmd.commit_free = 1'b1;
                end
                state_next = S_DONE;
            end
            S_ASCAN:
            begin
                if (stat.scan_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_EMPTY;
                    state_next     = S_DONE;
                end
                else if (stat.has_free)
                begin
                    if (stat.stacked)
                    begin
                        cmd.ram_rd = 1'b1;
                        state_next = S_APOP;
                    end
                    else
                    begin
                        cmd.commit_fresh = 1'b1;
                        state_next       = S_AMUL;
                    end
                end
                else
                begin
                    cmd.scan_dec = 1'b1;
                end
            end
            S_APOP:
            begin
                cmd.commit_pop = 1'b1;
                state_next     = S_AMUL;
            end
            S_AMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_IDX;
                state_next  = S_AADDR;
            end
            S_AADDR:
            begin
                cmd.set_addr   = 1'b1;
                cmd.set_status = 1'b1;
                cmd.code       = ST_OK;
                state_next     = S_DONE;
            end
            S_FSCAN:
            begin
                if (stat.scan_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_NOT_OWNED;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_TOTAL;
                    state_next  = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (stat.in_range)
                begin
                    if (stat.overflow)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = ST_OVERFLOW;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    cmd.scan_dec = 1'b1;
                    state_next   = S_FSCAN;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/fbsa_datapath.sv]
module fbsa_datapath #(
    parameter int MAX_SLABS       = fbsa_pkg::MAX_SLABS_DEF,
    parameter int BLOCKS_PER_SLAB = fbsa_pkg::BLOCKS_PER_SLAB_DEF,
    parameter int HEADER_BYTES    = fbsa_pkg::HEADER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      func,
    input  logic [fbsa_pkg::ADDR_W-1:0]     region_base,
    input  logic [fbsa_pkg::ADDR_W-1:0]     region_length,
    input  logic [fbsa_pkg::ADDR_W-1:0]     block_address,
    input  logic                            cfg_write,
    input  logic [fbsa_pkg::BS_W-1:0]       cfg_data,
    input  fbsa_pkg::dp_cmd_t               cmd,
    output fbsa_pkg::dp_stat_t              stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fbsa_pkg::ADDR_W-1:0]     granted_address,
    output logic [2:0]                      status,
    output logic [fbsa_pkg::FREE_OUT_W-1:0] free_blocks
);

    import fbsa_pkg::*;

    localparam int SLOT_W  = (BLOCKS_PER_SLAB > 1) ? $clog2(BLOCKS_PER_SLAB) : 1;
    localparam int CNT_W   = $clog2(BLOCKS_PER_SLAB + 1);
    localparam int SI_W    = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int SC_W    = $clog2(MAX_SLABS + 1);
    localparam int TOT_W   = $clog2(MAX_SLABS * BLOCKS_PER_SLAB + 1);
    localparam int PROD_W  = BS_W + CNT_W;
    localparam int CMP_W   = ((PROD_W > ADDR_W + 1) ? PROD_W : ADDR_W + 1) + 1;
    localparam int DSR_W   = BS_W + SLOT_W;
    localparam int REM_W   = (DSR_W > ADDR_W) ? DSR_W : ADDR_W;
    localparam int STEP_W  = (SLOT_W > 1) ? $clog2(SLOT_W) : 1;
    localparam int RAM_AW  = SI_W + SLOT_W;

    // configuration and captured item
    logic [BS_W-1:0]   block_size_reg;
    op_t               op_reg;
    logic [ADDR_W-1:0] base_in_reg;
    logic [ADDR_W-1:0] len_in_reg;
    logic [ADDR_W-1:0] baddr_reg;

    // slab table and totals
    logic [ADDR_W-1:0] slab_base_reg  [MAX_SLABS];
    logic [CNT_W-1:0]  slab_total_reg [MAX_SLABS];
    logic [CNT_W-1:0]  slab_free_reg  [MAX_SLABS];
    logic [CNT_W-1:0]  slab_fresh_reg [MAX_SLABS];
    logic [SLOT_W-1:0] slab_head_reg  [MAX_SLABS];
    logic [SC_W-1:0]   slab_count_reg;
    logic [TOT_W-1:0]  free_total_reg;
    logic [SC_W-1:0]   scan_reg;

    // arithmetic unit state
    logic [PROD_W-1:0] prod_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [SLOT_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SLOT_W-1:0] idx_reg;

    // result and output stage
    logic [ADDR_W-1:0]     res_addr_reg;
    status_t               res_status_reg;
    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    status_t               out_status_reg;
    logic [FREE_OUT_W-1:0] out_free_reg;

    logic [BS_W-1:0]     bs_eff;
    logic [SI_W-1:0]     s_cur;
    logic [SI_W-1:0]     s_new;
    logic [ADDR_W:0]     room;
    logic [ADDR_W:0]     len_c;
    logic [ADDR_W-1:0]   grow_d;
    logic [ADDR_W:0]     lo;
    logic [CMP_W-1:0]    hi;
    logic [ADDR_W-1:0]   free_d;
    logic [CNT_W-1:0]    mul_b;
    logic [CNT_W-1:0]    grow_n;
    logic                div_take;
    logic [SLOT_W-1:0]   ram_rd_data;
    logic [RAM_AW-1:0]   ram_wr_addr;
    logic [RAM_AW-1:0]   ram_rd_addr;

    // block size below the link size counts as the minimum
    assign bs_eff = (block_size_reg < BS_W'(BS_MIN)) ? BS_W'(BS_MIN) : block_size_reg;
    assign s_cur  = SI_W'(scan_reg - 1'b1);
    assign s_new  = SI_W'(slab_count_reg);

    // grow: clip region at top of address space, strip header
    assign room   = {1'b1, {ADDR_W{1'b0}}} - {1'b0, base_in_reg};
    assign len_c  = ({1'b0, len_in_reg} > room) ? room : {1'b0, len_in_reg};
    assign grow_d = ADDR_W'(len_c - (ADDR_W + 1)'(HEADER_BYTES));
    assign grow_n = cmd.grow_cap ? CNT_W'(BLOCKS_PER_SLAB) : CNT_W'(quo_reg);

    // free and alloc: block area of the scanned slab
    assign lo     = {1'b0, slab_base_reg[s_cur]} + (ADDR_W + 1)'(HEADER_BYTES);
    assign hi     = CMP_W'(lo) + CMP_W'(prod_reg);
    assign free_d = baddr_reg - lo[ADDR_W-1:0];

    // multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_CAP:   mul_b = CNT_W'(BLOCKS_PER_SLAB);
            MUL_TOTAL: mul_b = slab_total_reg[s_cur];
            MUL_IDX:   mul_b = CNT_W'(idx_reg);
            default:   mul_b = '0;
        endcase
    end

    assign div_take = REM_W'(dsr_reg) <= rem_reg;

    // status to controller
    assign stat.op         = op_reg;
    assign stat.slab_full  = slab_count_reg >= SC_W'(MAX_SLABS);
    assign stat.grow_small = len_c <= (ADDR_W + 1)'(HEADER_BYTES);
    assign stat.cap_hit    = CMP_W'(grow_d) >= CMP_W'(prod_reg);
    assign stat.scan_zero  = scan_reg == '0;
    assign stat.has_free   = slab_free_reg[s_cur] != '0;
    assign stat.stacked    = ((CNT_W + 1)'(slab_free_reg[s_cur])
                              + (CNT_W + 1)'(slab_fresh_reg[s_cur]))
                             != (CNT_W + 1)'(slab_total_reg[s_cur]);
    assign stat.in_range   = ({1'b0, baddr_reg} >= lo) && (CMP_W'(baddr_reg) < hi);
    assign stat.overflow   = slab_free_reg[s_cur] >= slab_total_reg[s_cur];
    assign stat.div_last   = step_reg == '0;
    assign stat.quo_zero   = quo_reg == '0;
    assign stat.baddr_zero = baddr_reg == '0;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BS_W'(BS_MIN);
            slab_count_reg <= '0;
            free_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                block_size_reg <= cfg_data;
            end
            if (cmd.commit_grow)
            begin
                slab_count_reg <= slab_count_reg + 1'b1;
                free_total_reg <= free_total_reg + TOT_W'(grow_n);
            end
            else if (cmd.commit_fresh || cmd.commit_pop)
            begin
                free_total_reg <= free_total_reg - 1'b1;
            end
            else if (cmd.commit_free)
            begin
                free_total_reg <= free_total_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture, scan index, arithmetic unit, results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op_t'(func);
            base_in_reg  <= region_base;
            len_in_reg   <= region_length;
            baddr_reg    <= block_address;
            scan_reg     <= slab_count_reg;
            res_addr_reg <= '0;
        end
        else if (cmd.scan_dec)
        begin
            scan_reg <= scan_reg - 1'b1;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(bs_eff) * PROD_W'(mul_b);
        end
        // restoring divide, one quotient bit per cycle
        if (cmd.div_start)
        begin
            rem_reg  <= (op_reg == OP_GROW) ? REM_W'(grow_d) : REM_W'(free_d);
            dsr_reg  <= DSR_W'(bs_eff) << (SLOT_W - 1);
            quo_reg  <= '0;
            step_reg <= STEP_W'(SLOT_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (div_take)
            begin
                rem_reg <= rem_reg - REM_W'(dsr_reg);
            end
            quo_reg  <= SLOT_W'({quo_reg, div_take});
            dsr_reg  <= dsr_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.commit_fresh)
        begin
            idx_reg <= SLOT_W'(slab_fresh_reg[s_cur]);
        end
        else if (cmd.commit_pop)
        begin
            idx_reg <= slab_head_reg[s_cur];
        end
        if (cmd.set_addr)
        begin
            res_addr_reg <= hi[ADDR_W-1:0];
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.code;
        end
        if (cmd.out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
            out_free_reg   <= FREE_OUT_W'(free_total_reg);
        end
    end

    // slab table updates
    always_ff @(posedge clk)
    begin
        if (cmd.commit_grow)
        begin
            slab_base_reg[s_new]  <= base_in_reg;
            slab_total_reg[s_new] <= grow_n;
            slab_free_reg[s_new]  <= grow_n;
            slab_fresh_reg[s_new] <= '0;
            slab_head_reg[s_new]  <= '0;
        end
        else if (cmd.commit_fresh)
        begin
            slab_fresh_reg[s_cur] <= slab_fresh_reg[s_cur] + 1'b1;
            slab_free_reg[s_cur]  <= slab_free_reg[s_cur] - 1'b1;
        end
        else if (cmd.commit_pop)
        begin
            slab_head_reg[s_cur] <= ram_rd_data;
            slab_free_reg[s_cur] <= slab_free_reg[s_cur] - 1'b1;
        end
        else if (cmd.commit_free)
        begin
            slab_head_reg[s_cur] <= quo_reg;
            slab_free_reg[s_cur] <= slab_free_reg[s_cur] + 1'b1;
        end
    end

    // per-block stack links
    assign ram_wr_addr = {s_cur, quo_reg};
    assign ram_rd_addr = {s_cur, slab_head_reg[s_cur]};

    fbsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (1 << RAM_AW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (cmd.commit_free),
        .wr_addr (ram_wr_addr),
        .wr_data (slab_head_reg[s_cur]),
        .rd_en   (cmd.ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign status          = out_status_reg;
    assign free_blocks     = out_free_reg;

endmodule

[hw/rtl/fbsa_checker.sv]
`include "fixed_block_slab_allocator_core_assert.svh"

module fbsa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [fbsa_pkg::ADDR_W-1:0] granted_address,
    input logic [2:0]                  status
);

    import fbsa_pkg::*;

    // a stalled result beat holds
    `FBSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(granted_address) && $stable(status))

    // one operation in flight: ready drops right after a beat is taken
    `FBSA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // a nonzero address only comes with success
    `FBSA_ASSERT_IMPLY(a_addr_ok, out_valid && granted_address != '0, status == ST_OK)

endmodule

bind fixed_block_slab_allocator_core fbsa_checker u_fbsa_checker (.*);
